// ----- rtl/pfra_pkg.sv -----
// Package: shared constants, types and codes of the page frame allocator.
package pfra_pkg;

   localparam int NUM_FRAMES  = 4096;
   localparam int FRAME_SHIFT = 12;
   localparam int IDX_W       = $clog2(NUM_FRAMES);
   localparam int ADDR_W      = 52;
   localparam int FREE_W      = 13;
   localparam int CNT_W       = 8;
   localparam logic [CNT_W-1:0] USED_COUNT = 8'd100;
   localparam logic [CNT_W-1:0] MAX_COUNT  = 8'd255;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_SHARE = 2'd2,
      OP_INIT  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_IGNORED      = 3'd1,
      ST_OOM          = 3'd2,
      ST_NONEXIST     = 3'd3,
      ST_ALREADY_FREE = 3'd4,
      ST_SATURATED    = 3'd5
   } status_type;

   localparam logic CSR_BASE  = 1'b0;
   localparam logic CSR_LIMIT = 1'b1;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_RD,
      S_RDWAIT,
      S_UPDATE,
      S_SCAN,
      S_SCANWAIT,
      S_SCANTEST,
      S_INIT,
      S_RESP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic       load_req;
      logic       idx_clear;
      logic       idx_load_top;
      logic       idx_dec;
      logic       idx_inc;
      logic       mem_rd;
      logic       wr_upd;
      logic       wr_init;
      logic       wr_clear;
      logic       wr_grant;
      logic       set_status;
      status_type status;
      logic       rsp_load;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      op_type     op;
      logic       idx_zero;
      logic       idx_last;
      status_type check_status;
      logic       check_ok;
      logic       cnt_zero;
      logic       cnt_max;
      logic       none_free;
   } stat_type;

endpackage

// ----- rtl/pfra_if.sv -----
// Interfaces: valid/ready channels for requests, responses and register writes.
interface pfra_req_if (input logic clock);
   logic                          valid;
   logic                          ready;
   logic [1:0]                    opcode;
   logic [pfra_pkg::ADDR_W-1:0]   frame_address;
   modport source (output valid, opcode, frame_address, input ready);
   modport sink (input valid, opcode, frame_address, output ready);
endinterface

interface pfra_rsp_if (input logic clock);
   logic                          valid;
   logic                          ready;
   logic [2:0]                    status;
   logic [pfra_pkg::ADDR_W-1:0]   granted_address;
   logic [pfra_pkg::FREE_W-1:0]   free_frames;
   modport source (output valid, status, granted_address, free_frames, input ready);
   modport sink (input valid, status, granted_address, free_frames, output ready);
endinterface

interface pfra_csr_if (input logic clock);
   logic                          valid;
   logic                          ready;
   logic                          index;
   logic [pfra_pkg::ADDR_W-1:0]   data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/pfra_ram.sv -----
// Generic single-port RAM with registered read.
module pfra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write or read one word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

// ----- rtl/pfra_datapath.sv -----
// Datapath: request registers, checks, count RAM, free counter and response.
module pfra_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  pfra_pkg::cmd_type      cmd,
   output pfra_pkg::stat_type     stat,
   input  logic [1:0]             req_opcode,
   input  logic [pfra_pkg::ADDR_W-1:0] req_addr,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [pfra_pkg::ADDR_W-1:0] csr_data,
   output logic [2:0]             rsp_status,
   output logic [pfra_pkg::ADDR_W-1:0] rsp_granted,
   output logic [pfra_pkg::FREE_W-1:0] rsp_free
);
   localparam int AW = pfra_pkg::ADDR_W;
   localparam int IW = pfra_pkg::IDX_W;
   localparam int FW = pfra_pkg::FREE_W;
   localparam int CW = pfra_pkg::CNT_W;
   localparam int SH = pfra_pkg::FRAME_SHIFT;

   logic [AW-1:0] base_ff, limit_ff, addr_ff;
   pfra_pkg::op_type op_ff;
   logic [IW-1:0] idx_ff, idx_in;
   logic [IW-1:0] span_ff;
   logic          span_full_ff;
   logic [FW-1:0] free_ff, free_in;
   pfra_pkg::status_type status_ff;
   logic [AW-1:0] granted_ff;
   logic [2:0]    rsp_status_ff;
   logic [AW-1:0] rsp_granted_ff;
   logic [FW-1:0] rsp_free_ff;
   logic [AW-1:0] diff_ff;
   pfra_pkg::status_type chk_status;

   logic [CW-1:0] rd_data, wr_data;
   logic          wr_en;

   // registers: config
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         limit_ff <= '0;
      end else if (csr_we) begin
         if (csr_index == pfra_pkg::CSR_BASE) base_ff <= csr_data;
         else limit_ff <= csr_data;
      end
   end

   // capture request and precompute address offset
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff   <= pfra_pkg::op_type'(req_opcode);
         addr_ff <= req_addr;
         diff_ff <= req_addr - base_ff;
      end
   end

   // range checks, combinational on the captured request registers
   logic [AW-1:0] sp_raw;
   logic          hi_zero;
   assign hi_zero = (diff_ff[AW-1:SH+IW] == '0);
   always_comb begin
      chk_status = pfra_pkg::ST_OK;
      if (addr_ff < base_ff) chk_status = pfra_pkg::ST_IGNORED;
      else if (op_ff == pfra_pkg::OP_FREE &&
               (addr_ff >= limit_ff || addr_ff[SH-1:0] != '0))
         chk_status = pfra_pkg::ST_NONEXIST;
      else if (!hi_zero) chk_status = pfra_pkg::ST_NONEXIST;
   end

   // init span: limit - base in frames, clipped to the store
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         sp_raw <= (limit_ff > base_ff) ? ((limit_ff - base_ff) >> SH) : '0;
      end
   end
   always_ff @(posedge clock) begin
      span_ff      <= sp_raw[IW-1:0];
      span_full_ff <= (sp_raw[AW-1:IW] != '0);
   end

   // index counter; the frame index of a request lands in the cycle after capture
   logic idx_from_req;
   always_ff @(posedge clock) begin
      if (reset) idx_from_req <= 1'b0;
      else idx_from_req <= cmd.load_req;
   end
   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clear) idx_in = '0;
      else if (cmd.idx_load_top) idx_in = '1;
      else if (cmd.idx_dec) idx_in = idx_ff - 1'b1;
      else if (cmd.idx_inc) idx_in = idx_ff + 1'b1;
      else if (idx_from_req) idx_in = diff_ff[SH+IW-1:SH];
   end
   always_ff @(posedge clock) begin
      if (reset) idx_ff <= '0;
      else idx_ff <= idx_in;
   end

   // count RAM write data
   always_comb begin
      wr_en   = cmd.wr_upd | cmd.wr_init | cmd.wr_clear | cmd.wr_grant;
      wr_data = '0;
      if (cmd.wr_grant) wr_data = 8'd1;
      else if (cmd.wr_init)
         wr_data = (span_full_ff || idx_ff < span_ff) ? '0 : pfra_pkg::USED_COUNT;
      else if (cmd.wr_upd)
         wr_data = (op_ff == pfra_pkg::OP_FREE) ? rd_data - 1'b1 : rd_data + 1'b1;
   end

   pfra_ram #(.WIDTH(CW), .DEPTH(pfra_pkg::NUM_FRAMES)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .addr   (idx_ff),
      .wr_data(wr_data),
      .rd_data(rd_data)
   );

   // free-frame counter, tracked incrementally
   always_comb begin
      free_in = free_ff;
      if (cmd.wr_clear) free_in = free_ff + 1'b1;
      else if (cmd.idx_clear && op_ff == pfra_pkg::OP_INIT && cmd.wr_init == 1'b0)
         free_in = '0;
      else if (cmd.wr_init) begin
         if (span_full_ff || idx_ff < span_ff) free_in = free_ff + 1'b1;
      end else if (cmd.wr_grant) free_in = free_ff - 1'b1;
      else if (cmd.wr_upd) begin
         if (op_ff == pfra_pkg::OP_FREE && rd_data == 8'd1) free_in = free_ff + 1'b1;
         else if (op_ff == pfra_pkg::OP_SHARE && rd_data == '0) free_in = free_ff - 1'b1;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) free_ff <= '0;
      else free_ff <= free_in;
   end

   // status and grant
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         status_ff  <= pfra_pkg::ST_OK;
         granted_ff <= '0;
      end else begin
         if (cmd.set_status) status_ff <= cmd.status;
         if (cmd.wr_grant) granted_ff <= base_ff + (AW'(idx_ff) << SH);
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff  <= status_ff;
         rsp_granted_ff <= granted_ff;
         rsp_free_ff    <= free_ff;
      end
   end
   assign rsp_status  = rsp_status_ff;
   assign rsp_granted = rsp_granted_ff;
   assign rsp_free    = rsp_free_ff;

   always_comb begin
      stat.op           = op_ff;
      stat.idx_zero     = (idx_ff == '0);
      stat.idx_last     = (idx_ff == '1);
      stat.check_status = chk_status;
      stat.check_ok     = (chk_status == pfra_pkg::ST_OK);
      stat.cnt_zero     = (rd_data == '0);
      stat.cnt_max      = (rd_data == pfra_pkg::MAX_COUNT);
      stat.none_free    = (free_ff == '0);
   end
endmodule

// ----- rtl/pfra_ctrl.sv -----
// Controller: sequences clearing, checks, scans, init sweeps and responses.
module pfra_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  pfra_pkg::stat_type stat,
   output pfra_pkg::cmd_type  cmd
);
   pfra_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfra_pkg::S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   logic rsp_free;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.status = pfra_pkg::ST_OK;
      req_ready = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         pfra_pkg::S_CLEAR: begin
            // sweep the store to zero after reset, one frame a cycle
            cmd.wr_clear = 1'b1;
            if (stat.idx_last) state_in = pfra_pkg::S_IDLE;
            else cmd.idx_inc = 1'b1;
         end
         pfra_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = pfra_pkg::S_CHECK;
            end
         end
         pfra_pkg::S_CHECK: begin
            unique case (stat.op)
               pfra_pkg::OP_ALLOC: begin
                  if (stat.none_free) begin
                     cmd.set_status = 1'b1;
                     cmd.status = pfra_pkg::ST_OOM;
                     state_in = pfra_pkg::S_RESP;
                  end else begin
                     cmd.idx_load_top = 1'b1;
                     state_in = pfra_pkg::S_SCAN;
                  end
               end
               pfra_pkg::OP_INIT: begin
                  cmd.idx_clear = 1'b1;
                  state_in = pfra_pkg::S_INIT;
               end
               default: begin
                  if (!stat.check_ok) begin
                     cmd.set_status = 1'b1;
                     cmd.status = stat.check_status;
                     state_in = pfra_pkg::S_RESP;
                  end else state_in = pfra_pkg::S_RD;
               end
            endcase
         end
         pfra_pkg::S_RD: begin
            cmd.mem_rd = 1'b1;
            state_in = pfra_pkg::S_RDWAIT;
         end
         pfra_pkg::S_RDWAIT: state_in = pfra_pkg::S_UPDATE;
         pfra_pkg::S_UPDATE: begin
            if (stat.op == pfra_pkg::OP_FREE && stat.cnt_zero) begin
               cmd.set_status = 1'b1;
               cmd.status = pfra_pkg::ST_ALREADY_FREE;
            end else if (stat.op == pfra_pkg::OP_SHARE && stat.cnt_max) begin
               cmd.set_status = 1'b1;
               cmd.status = pfra_pkg::ST_SATURATED;
            end else cmd.wr_upd = 1'b1;
            state_in = pfra_pkg::S_RESP;
         end
         pfra_pkg::S_SCAN: begin
            cmd.mem_rd = 1'b1;
            state_in = pfra_pkg::S_SCANWAIT;
         end
         pfra_pkg::S_SCANWAIT: state_in = pfra_pkg::S_SCANTEST;
         pfra_pkg::S_SCANTEST: begin
            // free frames exist, so the downward scan always hits one
            if (stat.cnt_zero) begin
               cmd.wr_grant = 1'b1;
               state_in = pfra_pkg::S_RESP;
            end else begin
               cmd.idx_dec = 1'b1;
               state_in = pfra_pkg::S_SCAN;
            end
         end
         pfra_pkg::S_INIT: begin
            cmd.wr_init = 1'b1;
            if (stat.idx_last) state_in = pfra_pkg::S_RESP;
            else cmd.idx_inc = 1'b1;
         end
         pfra_pkg::S_RESP: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = pfra_pkg::S_IDLE;
            end
         end
         default: state_in = pfra_pkg::S_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == pfra_pkg::S_IDLE) else $error("accept while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.wr_upd, cmd.wr_init, cmd.wr_clear, cmd.wr_grant}))
      else $error("multiple RAM writes");
`endif
endmodule

// ----- rtl/page_frame_refcount_allocator_unit.sv -----
// Top level: page frame allocator keeping an 8-bit reference count per frame.
// Channels: req (opcode, frame_address) in, rsp (status, granted_address,
// free_frames) out, csr (index, data) writes frame_base (0) and frame_limit (1).
// One request is in work at a time; a transfer on req happens only when idle.
// Free and share: after the req transfer come check, RAM read, read wait, update
// and response load; the next request is taken only once the response is loaded.
// Rejected free/share and out of memory go from check straight to response load.
// Alloc scans down from the top frame, a read, read wait and test per frame visited
// through the single RAM port, and loads the response on the first free frame.
// Init sweeps every frame once, then loads the response.
// The free count is kept incrementally alongside the RAM writes.
// After reset a clearing pass over all NUM_FRAMES frames zeroes the count RAM;
// no request is taken during it, csr writes are taken at any time.
// The response sits in an output register; while the receiver stalls, the next
// request is still taken and worked, but its response waits until that one leaves.
module page_frame_refcount_allocator_unit (
   input logic          clock,
   input logic          reset,
   pfra_req_if.sink     req,
   pfra_rsp_if.source   rsp,
   pfra_csr_if.sink     csr
);
   pfra_pkg::cmd_type  cmd;
   pfra_pkg::stat_type stat;
   logic [2:0] st;

   assign csr.ready = 1'b1;

   pfra_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req.valid),
      .req_ready(req.ready),
      .rsp_valid(rsp.valid),
      .rsp_ready(rsp.ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   pfra_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_opcode (req.opcode),
      .req_addr   (req.frame_address),
      .csr_we     (csr.valid),
      .csr_index  (csr.index),
      .csr_data   (csr.data),
      .rsp_status (st),
      .rsp_granted(rsp.granted_address),
      .rsp_free   (rsp.free_frames)
   );
   assign rsp.status = st;
endmodule
